FILE: hw/rtl/versatile_interface_adapter_timers_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interface adapter timers
// Concurrent check wrappers; compile with ASSERT_OFF to drop all of them.
// ----------------------------------------------------------------------------
`ifndef VERSATILE_INTERFACE_ADAPTER_TIMERS_TOP_DEFINES_SVH
`define VERSATILE_INTERFACE_ADAPTER_TIMERS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define VIA_TMR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("check failed: invariant");
// antecedent at one edge implies consequent at the next edge
`define VIA_TMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");
`else
`define VIA_TMR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define VIA_TMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/via_tmr_pkg.sv
// ----------------------------------------------------------------------------
// via_tmr_pkg
// Shared types, register map and reset values for the adapter timers.
// ----------------------------------------------------------------------------
package via_tmr_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int LINE_W   = 3;
    localparam int COUNT_W  = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_IRQ   = 2'd3
    } opcode_t;

    localparam logic [INDEX_W-1:0] REG_PORTB  = 4'd0;
    localparam logic [INDEX_W-1:0] REG_SPARE1 = 4'd1;
    localparam logic [INDEX_W-1:0] REG_DIRB   = 4'd2;
    localparam logic [INDEX_W-1:0] REG_SPARE3 = 4'd3;
    localparam logic [INDEX_W-1:0] REG_T1CL   = 4'd4;
    localparam logic [INDEX_W-1:0] REG_T1CH   = 4'd5;
    localparam logic [INDEX_W-1:0] REG_T1LL   = 4'd6;
    localparam logic [INDEX_W-1:0] REG_T1LH   = 4'd7;
    localparam logic [INDEX_W-1:0] REG_T2CL   = 4'd8;
    localparam logic [INDEX_W-1:0] REG_T2CH   = 4'd9;
    localparam logic [INDEX_W-1:0] REG_SR     = 4'd10;
    localparam logic [INDEX_W-1:0] REG_ACR    = 4'd11;
    localparam logic [INDEX_W-1:0] REG_PCR    = 4'd12;
    localparam logic [INDEX_W-1:0] REG_IFR    = 4'd13;
    localparam logic [INDEX_W-1:0] REG_IER    = 4'd14;
    localparam logic [INDEX_W-1:0] REG_PORTA  = 4'd15;

    // flag register bits and masks
    localparam logic [BYTE_W-1:0] IRQ_BIT      = 8'h80;
    localparam logic [BYTE_W-1:0] FLAG_MASK    = 8'h7f;
    localparam logic [BYTE_W-1:0] T1_FLAG      = 8'h40;
    localparam logic [BYTE_W-1:0] T2_FLAG      = 8'h20;
    localparam logic [BYTE_W-1:0] SR_FLAG      = 8'h04;
    localparam logic [BYTE_W-1:0] T1_FLAG_SET  = 8'hc0;
    localparam logic [BYTE_W-1:0] T2_FLAG_SET  = 8'ha0;
    localparam logic [COUNT_W-1:0] COUNT_WRAP  = 16'hffff;

    localparam logic [BYTE_W-1:0] PORTA_RESET = 8'h10;
    localparam logic [BYTE_W-1:0] IER_RESET   = 8'h80;

    typedef struct packed {
        logic [BYTE_W-1:0]  port_b;
        logic [BYTE_W-1:0]  spare1;
        logic [BYTE_W-1:0]  dir_b;
        logic [BYTE_W-1:0]  spare3;
        logic [BYTE_W-1:0]  sr;
        logic [BYTE_W-1:0]  acr;
        logic [BYTE_W-1:0]  pcr;
        logic [BYTE_W-1:0]  ifr;
        logic [BYTE_W-1:0]  ier;
        logic [BYTE_W-1:0]  port_a;
        logic [COUNT_W-1:0] t1_count;
        logic [COUNT_W-1:0] t1_latch;
        logic [COUNT_W-1:0] t2_count;
        logic [BYTE_W-1:0]  t2_latch_low;
        logic               t1_armed;
        logic               t2_armed;
    } via_state_t;

    localparam via_state_t STATE_RESET = '{
        port_b:       '0,
        spare1:       '0,
        dir_b:        '0,
        spare3:       '0,
        sr:           '0,
        acr:          '0,
        pcr:          '0,
        ifr:          '0,
        ier:          IER_RESET,
        port_a:       PORTA_RESET,
        t1_count:     '0,
        t1_latch:     '0,
        t2_count:     '0,
        t2_latch_low: '0,
        t1_armed:     1'b0,
        t2_armed:     1'b0
    };

endpackage

FILE: hw/rtl/via_tmr_step.sv
// ----------------------------------------------------------------------------
// via_tmr_step
// Next-state and read-data logic for one bus access, tick or interrupt.
// ----------------------------------------------------------------------------
module via_tmr_step (
    input  via_tmr_pkg::via_state_t             state_cur,
    input  logic [via_tmr_pkg::OPCODE_W-1:0]    opcode,
    input  logic [via_tmr_pkg::INDEX_W-1:0]     reg_index,
    input  logic [via_tmr_pkg::BYTE_W-1:0]      write_data,
    input  logic [via_tmr_pkg::LINE_W-1:0]      irq_line,
    output via_tmr_pkg::via_state_t             state_next,
    output logic [via_tmr_pkg::BYTE_W-1:0]      read_data
);
    import via_tmr_pkg::*;

    // set or clear under bit 7, then recompute the summary bit
    function automatic logic [BYTE_W-1:0] flags_apply(
        input logic [BYTE_W-1:0] ifr,
        input logic [BYTE_W-1:0] ier,
        input logic [BYTE_W-1:0] v
    );
        logic [BYTE_W-1:0] f;
        f = v[7] ? (ifr | v) : (ifr & ~v);
        f = f & FLAG_MASK;
        if ((ier & f) != '0) begin
            f = f | IRQ_BIT;
        end
        return f;
    endfunction

    via_state_t nxt;
    logic [BYTE_W-1:0] rd;

    always_comb begin
        nxt = state_cur;
        rd  = '0;
        unique case (opcode_t'(opcode))
            OP_READ: begin
                unique case (reg_index)
                    REG_PORTB:  rd = state_cur.port_b;
                    REG_SPARE1: rd = state_cur.spare1;
                    REG_DIRB:   rd = state_cur.dir_b;
                    REG_SPARE3: rd = state_cur.spare3;
                    REG_T1CL: begin
                        rd = state_cur.t1_count[7:0];
                        nxt.t1_armed = 1'b1;
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T1_FLAG);
                    end
                    REG_T1CH:   rd = state_cur.t1_count[15:8];
                    REG_T1LL:   rd = state_cur.t1_latch[7:0];
                    REG_T1LH:   rd = state_cur.t1_latch[15:8];
                    REG_T2CL: begin
                        rd = state_cur.t2_count[7:0];
                        nxt.t2_armed = 1'b1;
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T2_FLAG);
                    end
                    REG_T2CH:   rd = state_cur.t2_count[15:8];
                    REG_SR: begin
                        rd = state_cur.sr;
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, SR_FLAG);
                    end
                    REG_ACR:    rd = state_cur.acr;
                    REG_PCR:    rd = state_cur.pcr;
                    REG_IFR:    rd = state_cur.ifr;
                    REG_IER:    rd = state_cur.ier;
                    REG_PORTA:  rd = state_cur.port_a;
                    default:    rd = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (reg_index)
                    REG_PORTB:  nxt.port_b = write_data;
                    REG_SPARE1: nxt.spare1 = write_data;
                    REG_DIRB:   nxt.dir_b  = write_data;
                    REG_SPARE3: nxt.spare3 = write_data;
                    REG_T1CL, REG_T1LL: nxt.t1_latch[7:0] = write_data;
                    REG_T1CH: begin
                        nxt.t1_latch[15:8] = write_data;
                        nxt.t1_count = {write_data, state_cur.t1_latch[7:0]};
                        nxt.t1_armed = 1'b1;
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T1_FLAG);
                        if (state_cur.acr[7]) begin
                            nxt.port_b[7] = 1'b0;
                        end
                    end
                    REG_T1LH: begin
                        nxt.t1_latch[15:8] = write_data;
                        nxt.t1_armed = 1'b1;
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T1_FLAG);
                    end
                    REG_T2CL:   nxt.t2_latch_low = write_data;
                    REG_T2CH: begin
                        nxt.t2_count = {write_data, state_cur.t2_latch_low};
                        nxt.t2_armed = 1'b1;
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T2_FLAG);
                    end
                    REG_SR:     nxt.sr  = write_data;
                    REG_ACR:    nxt.acr = write_data;
                    REG_PCR:    nxt.pcr = write_data;
                    REG_IFR: begin
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, write_data);
                    end
                    REG_IER: begin
                        nxt.ier = (write_data[7] ? (state_cur.ier | write_data)
                                                 : (state_cur.ier & ~write_data)) | IRQ_BIT;
                    end
                    REG_PORTA:  nxt.port_a = write_data;
                    default:    nxt = state_cur;
                endcase
            end
            OP_TICK: begin
                // timer 1 first, then timer 2 sees its flag update
                if (state_cur.t1_count != '0) begin
                    nxt.t1_count = state_cur.t1_count - 16'd1;
                end else if (state_cur.acr[6]) begin
                    nxt.t1_count = state_cur.t1_latch;
                    if (state_cur.acr[7]) begin
                        nxt.port_b[7] = ~state_cur.port_b[7];
                    end
                    nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T1_FLAG_SET);
                end else begin
                    nxt.t1_count = COUNT_WRAP;
                    if (state_cur.acr[7]) begin
                        nxt.port_b[7] = 1'b1;
                    end
                    if (state_cur.t1_armed) begin
                        nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier, T1_FLAG_SET);
                        nxt.t1_armed = 1'b0;
                    end
                end
                if (state_cur.t2_count != '0) begin
                    nxt.t2_count = state_cur.t2_count - 16'd1;
                end else begin
                    nxt.t2_count = COUNT_WRAP;
                    if (state_cur.t2_armed) begin
                        nxt.ifr = flags_apply(nxt.ifr, state_cur.ier, T2_FLAG_SET);
                        nxt.t2_armed = 1'b0;
                    end
                end
            end
            OP_IRQ: begin
                nxt.ifr = flags_apply(state_cur.ifr, state_cur.ier,
                                      (8'd1 << irq_line) | IRQ_BIT);
            end
        endcase
    end

    assign state_next = nxt;
    assign read_data  = rd;

endmodule

FILE: hw/rtl/versatile_interface_adapter_timers_top.sv
// ----------------------------------------------------------------------------
// versatile_interface_adapter_timers_top
// Register bus plus two timers: bus reads and writes, ticks, interrupt lines.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   s_      | opcode, reg_index, write_data, irq_line       | in
//   m_      | read_data, irq_out, port_b_out, port_a_out    | out
//
// One transfer per cycle: each accepted item updates the state and the
// result register in the same edge, so the rate is one item per clock while m_ready is high.
// The only loop is the state register through the step logic.
// Reset (aresetn low, synchronous) loads the register file defaults.
// A stalled result holds in place; a new item is taken in the cycle the
// old result leaves, so input and output move together under back-pressure.
// ----------------------------------------------------------------------------
`include "versatile_interface_adapter_timers_top_defines.svh"

module versatile_interface_adapter_timers_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [via_tmr_pkg::OPCODE_W-1:0]    s_opcode,
    input  logic [via_tmr_pkg::INDEX_W-1:0]     s_reg_index,
    input  logic [via_tmr_pkg::BYTE_W-1:0]      s_write_data,
    input  logic [via_tmr_pkg::LINE_W-1:0]      s_irq_line,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [via_tmr_pkg::BYTE_W-1:0]      m_read_data,
    output logic                                m_irq_out,
    output logic [via_tmr_pkg::BYTE_W-1:0]      m_port_b_out,
    output logic [via_tmr_pkg::BYTE_W-1:0]      m_port_a_out
);
    import via_tmr_pkg::*;

    via_state_t         state_reg;
    via_state_t         state_next;
    logic [BYTE_W-1:0]  read_data_next;
    logic [BYTE_W-1:0]  read_data_reg;
    logic               m_valid_reg;
    logic               accept;
    logic               chk_not_read;
    logic               chk_tick_run;
    logic               chk_t1cl_read;
    logic [COUNT_W-1:0] t1_count_dec;

    // take a new transfer whenever the result slot is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    via_tmr_step u_step (
        .state_cur  (state_reg),
        .opcode     (s_opcode),
        .reg_index  (s_reg_index),
        .write_data (s_write_data),
        .irq_line   (s_irq_line),
        .state_next (state_next),
        .read_data  (read_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            // hold the result until taken, refill on accept
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= read_data_next;
        end
    end

    // port and irq outputs are the state left by the last accepted item
    assign m_valid      = m_valid_reg;
    assign m_read_data  = read_data_reg;
    assign m_irq_out    = state_reg.ifr[7];
    assign m_port_b_out = state_reg.port_b;
    assign m_port_a_out = state_reg.port_a;

    // conditions watched by the checks below
    assign chk_not_read  = accept && (s_opcode != OP_READ);
    assign chk_tick_run  = accept && (s_opcode == OP_TICK) && (state_reg.t1_count != '0);
    assign chk_t1cl_read = accept && (s_opcode == OP_READ) && (s_reg_index == REG_T1CL);
    assign t1_count_dec  = state_reg.t1_count - 16'd1;

    `VIA_TMR_ASSERT_ALWAYS(a_ier_top_set, aclk, aresetn, state_reg.ier[7])
    `VIA_TMR_ASSERT_NEXT(a_rd_zero, aclk, aresetn, chk_not_read, m_read_data == '0)
    `VIA_TMR_ASSERT_NEXT(a_t1_dec, aclk, aresetn, chk_tick_run, state_reg.t1_count == $past(t1_count_dec))
    `VIA_TMR_ASSERT_NEXT(a_t1cl_arm, aclk, aresetn, chk_t1cl_read, state_reg.t1_armed && !state_reg.ifr[6])

endmodule
